[design/sstf_pkg.sv]
// Package for the shortest-seek-first scheduler.
// Holds field widths, command codes, channel payload types and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package sstf_pkg;

    // Default sizes for the top-level parameters.
    localparam int MAX_REQUESTS_DEF = 16;
    localparam int TRACK_BITS_DEF   = 12;

    // Fixed widths of the channel fields.
    localparam int TRACK_W = 12;
    localparam int DIST_W  = 12;
    localparam int TOTAL_W = 16;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Input item commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Input item payload.
    typedef struct packed {
        logic               cmd;
        logic [TRACK_W-1:0] track;
    } sstf_req_t;

    // Result item payload.
    typedef struct packed {
        logic               served_valid;
        logic [TRACK_W-1:0] served_track;
        logic [DIST_W-1:0]  seek_distance;
        logic [TOTAL_W-1:0] total_movement;
        logic               dropped_loads;
        logic               last_of_run;
    } sstf_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start;
        logic scan_step;
        logic emit;
    } sstf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
        logic run_last;
    } sstf_sts_t;

endpackage

`default_nettype wire

[design/sstf_if.sv]
// Valid/ready channel interfaces for the scheduler's request and result items.
// Depends on sstf_pkg for the payload types.
`default_nettype none

interface sstf_req_if;
    import sstf_pkg::*;

    logic      valid;
    logic      ready;
    sstf_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sstf_rsp_if;
    import sstf_pkg::*;

    logic      valid;
    logic      ready;
    sstf_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/sstf_ctrl.sv]
// Controller state machine for the shortest-seek-first scheduler.
// Depends on sstf_pkg; drives the datapath through sstf_cmd_t.
`default_nettype none

module sstf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_cmd,
    output logic               in_ready,
    input  sstf_pkg::sstf_sts_t sts,
    output sstf_pkg::sstf_cmd_t cmd
);
    import sstf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Items are taken only between runs.
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Commands to the datapath.
    always_comb
    begin
        cmd.load      = accept && (in_cmd == CMD_LOAD);
        cmd.start     = accept && (in_cmd == CMD_RUN);
        cmd.scan_step = (state_reg == ST_SCAN);
        cmd.emit      = (state_reg == ST_EMIT) && sts.out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_cmd == CMD_RUN))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.run_last ? ST_IDLE : ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[design/sstf_dpath.sv]
// Datapath for the shortest-seek-first scheduler: request memory, pending
// bits, nearest-track scan, running totals and the result register.
// Depends on sstf_pkg; controlled through sstf_cmd_t.
`default_nettype none

module sstf_dpath #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [sstf_pkg::TRACK_W-1:0]  in_track,
    input  sstf_pkg::sstf_cmd_t                cmd,
    output sstf_pkg::sstf_sts_t                sts,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output sstf_pkg::sstf_rsp_t                out_data
);
    import sstf_pkg::*;

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    // Request track memory, written on loads and read by the scan.
    logic [TRACK_BITS-1:0] mem [MAX_REQUESTS];

    logic [MAX_REQUESTS-1:0] pend_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        remain_reg;
    logic [CNT_W-1:0]        issue_reg;
    logic [TRACK_BITS-1:0]   head_reg;
    logic [TOTAL_W-1:0]      total_reg;
    logic                    ovf_reg;
    logic                    rd_vld_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic [TRACK_BITS-1:0]   rd_trk_reg;
    logic                    found_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic [TRACK_BITS-1:0]   best_trk_reg;
    logic [TRACK_BITS-1:0]   best_d_reg;
    logic                    out_vld_reg;
    sstf_rsp_t               out_data_reg;

    logic [TRACK_BITS+TRACK_W-1:0] trk_in_ext;
    logic [TRACK_BITS-1:0]         trk_in;
    logic                          room;
    logic                          issue_more;
    logic [TRACK_BITS-1:0]         seek_d;
    logic                          better;
    logic [TOTAL_W:0]              sum;
    logic [TOTAL_W-1:0]            total_sat;
    logic [TRACK_BITS+TRACK_W-1:0] best_trk_ext;
    logic [TRACK_BITS+DIST_W-1:0]  best_d_ext;
    logic                          last;

    // Input track fitted to the internal track width.
    assign trk_in_ext = {{TRACK_BITS{1'b0}}, in_track};
    assign trk_in     = trk_in_ext[TRACK_BITS-1:0];

    assign room       = (count_reg < CNT_W'(MAX_REQUESTS));
    assign issue_more = (issue_reg < count_reg);

    // Distance of the entry just read from the head, and the strict
    // compare that keeps the earliest entry on a tie.
    assign seek_d = (rd_trk_reg > head_reg) ? (rd_trk_reg - head_reg)
                                            : (head_reg - rd_trk_reg);
    assign better = rd_vld_reg && pend_reg[rd_idx_reg] && (!found_reg || (seek_d < best_d_reg));

    // Saturating running total.
    assign sum       = {1'b0, total_reg} + (TOTAL_W + 1)'(best_d_reg);
    assign total_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    // Result fields masked to their output widths.
    assign best_trk_ext = {{TRACK_W{1'b0}}, best_trk_reg};
    assign best_d_ext   = {{DIST_W{1'b0}}, best_d_reg};

    // The current result closes the run when at most one request remains.
    assign last = (remain_reg == CNT_W'(0)) || (remain_reg == CNT_W'(1));

    // Status to the controller.
    always_comb
    begin
        sts.scan_done = !issue_more && !rd_vld_reg;
        sts.out_free  = !out_vld_reg || out_ready;
        sts.run_last  = last;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // Memory write on loads and registered read during the scan.
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            mem[count_reg[IDX_W-1:0]] <= trk_in;
        end
        rd_trk_reg <= mem[issue_reg[IDX_W-1:0]];
        rd_idx_reg <= issue_reg[IDX_W-1:0];
    end

    // Queue state: pending bits, fill count and overflow flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (room)
            begin
                pend_reg[count_reg[IDX_W-1:0]] <= 1'b1;
                count_reg <= count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            if (last)
            begin
                pend_reg  <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else if (found_reg)
            begin
                pend_reg[best_idx_reg] <= 1'b0;
            end
        end
    end

    // Run state: head, total, remaining count and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            total_reg  <= '0;
            remain_reg <= '0;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (cmd.start)
        begin
            head_reg   <= trk_in;
            total_reg  <= '0;
            remain_reg <= count_reg;
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (cmd.emit)
        begin
            if (found_reg)
            begin
                head_reg   <= best_trk_reg;
                total_reg  <= total_sat;
                remain_reg <= remain_reg - CNT_W'(1);
            end
            issue_reg  <= '0;
            rd_vld_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            rd_vld_reg <= issue_more;
            if (issue_more)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // Best candidate of the current scan.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && better)
        begin
            best_idx_reg <= rd_idx_reg;
            best_trk_reg <= rd_trk_reg;
            best_d_reg   <= seek_d;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.dropped_loads <= ovf_reg;
            out_data_reg.last_of_run   <= last;
            if (found_reg)
            begin
                out_data_reg.served_valid   <= 1'b1;
                out_data_reg.served_track   <= best_trk_ext[TRACK_W-1:0];
                out_data_reg.seek_distance  <= best_d_ext[DIST_W-1:0];
                out_data_reg.total_movement <= total_sat;
            end
            else
            begin
                out_data_reg.served_valid   <= 1'b0;
                out_data_reg.served_track   <= '0;
                out_data_reg.seek_distance  <= '0;
                out_data_reg.total_movement <= '0;
            end
        end
    end

endmodule

`default_nettype wire

[design/shortest_seek_first_scheduler.sv]
// Top level of the shortest-seek-first disk request scheduler.
// Depends on sstf_pkg, sstf_if, sstf_ctrl and sstf_dpath.
//
//   Channel  Modport  Payload                      Role
//   req      sink     cmd, track                   load a request or start a run
//   rsp      source   served_valid .. last_of_run  one item per served request or empty run
//
// A run over N queued requests gives N result items; each one takes N reads
// through the request memory's single read port, the registered read, a
// check that the scan has finished and the load of the result register.
// An empty run still gives a single result item.
// Reset empties the queue and clears head, total and overflow at once.
// A stalled result holds its register; the next scan still runs, and the
// following result waits for the register to drain. Requests are refused
// while a run is in progress.
`default_nettype none

module shortest_seek_first_scheduler #(
    parameter int MAX_REQUESTS = sstf_pkg::MAX_REQUESTS_DEF,
    parameter int TRACK_BITS   = sstf_pkg::TRACK_BITS_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    sstf_req_if.sink    req,
    sstf_rsp_if.source  rsp
);
    import sstf_pkg::*;

    sstf_cmd_t cmd;
    sstf_sts_t sts;

    // Sequencer.
    sstf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (req.data.cmd),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Queue, scan and result register.
    sstf_dpath #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_track  (req.data.track),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_data  (rsp.data)
    );

endmodule

`default_nettype wire
